FILE: sv/edge_walker_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Edge walker assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef EDGE_WALKER_INTERPOLATOR_DEFINES_SVH
`define EDGE_WALKER_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication on clk_i, off while rst_ni is low
`define EWI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edge walker check failed");

// Next-cycle implication on clk_i, off while rst_ni is low
`define EWI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edge walker check failed");

`endif

FILE: sv/ewi_pkg.sv
// ----------------------------------------------------------------------------
// ewi_pkg
// Types and constants shared by the edge walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ewi_pkg;

  localparam int DATA_W    = 32;
  localparam int N_CH      = 5;               // x, depth, red, green, blue
  localparam int N_TOP     = 6;               // y plus the five channels
  localparam int CH_W      = 3;
  localparam int IN_W      = N_TOP * DATA_W;
  localparam int OUT_W     = N_CH * DATA_W;
  localparam int DIV_STEPS = DATA_W;          // one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(N_CH - 1);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SETUP = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_top;
    logic            cap_setup;
    logic            step;
    logic            diff_ld;
    logic            div_start;
    logic            inc_wr;
    logic            walk_init;
    logic            out_load;
    logic            out_flag;
    logic [CH_W-1:0] ch;
  } ewi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic height_pos;
    logic div_done;
  } ewi_sts_t;

endpackage

FILE: sv/ewi_div.sv
// ----------------------------------------------------------------------------
// ewi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewi_div #(
  parameter int HW = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ewi_pkg::DATA_W-1:0] dividend_i,
  input  logic [HW-1:0]              divisor_i,
  output logic                       done_o,
  output logic [ewi_pkg::DATA_W-1:0] quot_o
);
  import ewi_pkg::*;

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [HW-1:0]        rem_q;
  logic [DATA_W-1:0]    quo_q;

  logic [HW:0]          shifted;
  logic [HW:0]          trial;
  logic                 ge;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, divisor_i};
  assign ge      = ~trial[HW];

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= ge ? trial[HW-1:0] : shifted[HW-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: sv/ewi_dp.sv
// ----------------------------------------------------------------------------
// ewi_dp
// Edge walker datapath: vertex store, walker, increments, divider, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewi_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ewi_pkg::ewi_cmd_t         cmd_i,
  output ewi_pkg::ewi_sts_t         sts_o,
  input  logic [ewi_pkg::IN_W-1:0]  in_data_i,
  output logic [ewi_pkg::OUT_W-1:0] out_data_o,
  output logic                      out_flag_o
);
  import ewi_pkg::*;

  localparam int IW = DATA_W - FRAC_BITS;     // integer bits of a coordinate

  logic [DATA_W-1:0] top_q  [N_TOP];
  logic [DATA_W-1:0] bot_q  [N_CH];
  logic [DATA_W-1:0] walk_q [N_CH];
  logic [DATA_W-1:0] inc_q  [N_CH];
  logic [IW:0]       height_q;
  logic [DATA_W:0]   diff_q;
  logic              neg_q;
  logic [OUT_W-1:0]  out_data_q;
  logic              out_flag_q;

  logic [DATA_W-1:0] in_y;
  logic [DATA_W-1:0] top_y;
  logic [IW-1:0]     ip_bot;
  logic [IW-1:0]     ip_top;
  logic [IW:0]       height_d;
  logic [DATA_W-1:0] bot_sel;
  logic [DATA_W-1:0] top_sel;
  logic [DATA_W:0]   diff_d;
  logic [DATA_W:0]   diff_neg;
  logic [DATA_W-1:0] mag;
  logic              div_done;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] inc_new;

  // Integer part of y, truncated toward zero
  assign in_y   = in_data_i[DATA_W-1:0];
  assign top_y  = top_q[0];
  assign ip_bot = in_y[DATA_W-1:FRAC_BITS]
                  + IW'(in_y[DATA_W-1] & (|in_y[FRAC_BITS-1:0]));
  assign ip_top = top_y[DATA_W-1:FRAC_BITS]
                  + IW'(top_y[DATA_W-1] & (|top_y[FRAC_BITS-1:0]));
  assign height_d = {ip_bot[IW-1], ip_bot} - {ip_top[IW-1], ip_top};

  // Per-channel difference, bottom minus top
  assign bot_sel = bot_q[cmd_i.ch];
  assign top_sel = top_q[cmd_i.ch + CH_W'(1)];
  assign diff_d  = {bot_sel[DATA_W-1], bot_sel} - {top_sel[DATA_W-1], top_sel};

  // Magnitude for the unsigned divider; always fits in DATA_W bits
  assign diff_neg = ~diff_q + (DATA_W + 1)'(1);
  assign mag      = diff_q[DATA_W] ? diff_neg[DATA_W-1:0] : diff_q[DATA_W-1:0];

  ewi_div #(
    .HW (IW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (height_q[IW-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Signed quotient, low bits kept
  assign inc_new = neg_q ? (~quot + DATA_W'(1)) : quot;

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_TOP; i++) top_q[i] <= '0;
      for (int i = 0; i < N_CH; i++) begin
        walk_q[i] <= '0;
        inc_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.load_top) begin
        for (int i = 0; i < N_TOP; i++) top_q[i] <= in_data_i[i*DATA_W +: DATA_W];
      end
      if (cmd_i.step) begin
        for (int i = 0; i < N_CH; i++) walk_q[i] <= walk_q[i] + inc_q[i];
      end
      if (cmd_i.walk_init) begin
        for (int i = 0; i < N_CH; i++) walk_q[i] <= top_q[i+1];
      end
      if (cmd_i.inc_wr) begin
        inc_q[cmd_i.ch] <= inc_new;
      end
    end
  end

  // Setup working registers and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_setup) begin
      height_q <= height_d;
      for (int i = 0; i < N_CH; i++) bot_q[i] <= in_data_i[(i+1)*DATA_W +: DATA_W];
    end
    if (cmd_i.diff_ld) begin
      diff_q <= diff_d;
    end
    if (cmd_i.div_start) begin
      neg_q <= diff_q[DATA_W];
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < N_CH; i++) out_data_q[i*DATA_W +: DATA_W] <= walk_q[i];
      out_flag_q <= cmd_i.out_flag;
    end
  end

  assign sts_o.height_pos = ~height_q[IW] & (|height_q[IW-1:0]);
  assign sts_o.div_done   = div_done;
  assign out_data_o       = out_data_q;
  assign out_flag_o       = out_flag_q;

endmodule

FILE: sv/ewi_ctrl.sv
// ----------------------------------------------------------------------------
// ewi_ctrl
// Edge walker controller: item sequencing and output register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  ewi_pkg::action_e  action_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output ewi_pkg::ewi_cmd_t cmd_o,
  input  ewi_pkg::ewi_sts_t sts_i
);
  import ewi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIFF,
    ST_START,
    ST_WAIT,
    ST_DELIVER
  } state_e;

  state_e          state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic            flag_q, flag_d;
  logic            out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    flag_d    = flag_q;
    cmd_o     = '0;
    cmd_o.ch  = ch_q;
    cmd_o.out_flag = flag_q;
    s_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          flag_d = 1'b0;
          case (action_i)
            ACT_LOAD: begin
              cmd_o.load_top = 1'b1;
              state_d        = ST_DELIVER;
            end
            ACT_SETUP: begin
              cmd_o.cap_setup = 1'b1;
              state_d         = ST_CHECK;
            end
            ACT_STEP: begin
              cmd_o.step = 1'b1;
              state_d    = ST_DELIVER;
            end
            default: begin
              state_d = ST_DELIVER;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (sts_i.height_pos) begin
          ch_d    = '0;
          state_d = ST_DIFF;
        end else begin
          flag_d  = 1'b1;
          state_d = ST_DELIVER;
        end
      end
      ST_DIFF: begin
        cmd_o.diff_ld = 1'b1;
        state_d       = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.inc_wr = 1'b1;
          if (ch_q == LAST_CH) begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_DELIVER;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_DIFF;
          end
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register holds until the transfer completes
    out_valid_d = cmd_o.out_load | (out_valid_q & ~m_ready_i);
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

FILE: sv/edge_walker_interpolator.sv
// ----------------------------------------------------------------------------
// edge_walker_interpolator
// Scanline edge walker with Gouraud interpolation of depth and color.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata                                    tuser
//  s_axis   in   y, x, depth, red, green, blue (6 x 32)   action (2)
//  m_axis   out  x, depth, red, green, blue (5 x 32)      degenerate (1)
//
//  Load, step and unused actions pass through the deliver state before tready returns.
//  Setup: the shared divider runs once per channel, five channels, each through
//  the diff, start and wait states; a degenerate setup skips the divider.
//  Reset clears the top vertex, walker values and increments to zero.
//  A result waits in the output register; the next item is taken meanwhile,
//  and the block stalls only when a second result is ready to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_walker_interpolator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // vert_y, vert_x, vert_depth, vert_red, vert_green, vert_blue
  input  logic [ewi_pkg::IN_W-1:0]  s_axis_tdata_i,
  // action
  input  logic [1:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // cur_x, cur_depth, cur_red, cur_green, cur_blue
  output logic [ewi_pkg::OUT_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                      m_axis_tuser_o
);
  import ewi_pkg::*;

  ewi_cmd_t cmd;
  ewi_sts_t sts;

  // Sequencer
  ewi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .action_i  (action_e'(s_axis_tuser_i)),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // Arithmetic and storage
  ewi_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_flag_o (m_axis_tuser_o)
  );

endmodule

FILE: sv/ewi_checker.sv
// ----------------------------------------------------------------------------
// ewi_checker
// Port-level checks of the edge walker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "edge_walker_interpolator_defines.svh"

module ewi_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [1:0]                s_axis_tuser_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ewi_pkg::OUT_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tuser_o
);
  import ewi_pkg::*;

  // Stalled result holds
  `EWI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // One item at a time: ready drops after each input transfer
  `EWI_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // A non-setup item has its result waiting after the deliver state loads the output register
  `EWI_ASSERT_NEXT(a_fast_result,
                   s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != ACT_SETUP),
                   ##1 m_axis_tvalid_o)

  // Ready returns only with a result in the output register
  `EWI_ASSERT_NOW(a_ready_result, $rose(s_axis_tready_o), m_axis_tvalid_o)

endmodule

bind edge_walker_interpolator ewi_checker u_ewi_checker (.*);
